// ===== sv/multi_mode_line_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// multi_mode_line_encoder_assert.svh
// Assertion macros used by the line encoder checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_LINE_ENCODER_ASSERT_SVH
`define MULTI_MODE_LINE_ENCODER_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define LME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, disabled during reset.
`define LME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the next cycle, active during reset as well.
`define LME_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lme_pkg.sv =====
// ----------------------------------------------------------------------------
// lme_pkg
// Types and constants of the multi-mode line encoder.
// ----------------------------------------------------------------------------
package lme_pkg;

  // Selectable line codes.
  typedef enum logic [1:0] {
    CODE_NRZI       = 2'd0,
    CODE_NRZ        = 2'd1,
    CODE_MANCHESTER = 2'd2,
    CODE_DIFF_MANCH = 2'd3
  } line_code_t;

  localparam line_code_t LINE_CODE_RESET = CODE_MANCHESTER;

  // Frame preamble pair, also the previous pair after reset.
  localparam logic PREAMBLE_FIRST  = 1'b0;
  localparam logic PREAMBLE_SECOND = 1'b1;

  // Work handed from the input stage to the coder.
  typedef struct packed {
    logic valid;
    logic send_preamble;
    logic data_bit;
  } issue_t;

  // One result pair with its flags.
  typedef struct packed {
    logic first_half;
    logic second_half;
    logic is_preamble;
    logic last;
  } result_t;

endpackage

// ===== sv/lme_if.sv =====
// ----------------------------------------------------------------------------
// lme_if
// Valid/ready channels of the line encoder: source bits, line levels and
// the line code register write.
// ----------------------------------------------------------------------------
interface lme_bit_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_start;

  modport source (output valid, output data_bit, output frame_start, input ready);
  modport sink   (input valid, input data_bit, input frame_start, output ready);
endinterface

interface lme_level_if;
  logic valid;
  logic ready;
  logic first_half;
  logic second_half;
  logic is_preamble;
  logic last;

  modport source (output valid, output first_half, output second_half,
                  output is_preamble, output last, input ready);
  modport sink   (input valid, input first_half, input second_half,
                  input is_preamble, input last, output ready);
endinterface

interface lme_cfg_if import lme_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] line_code;

  modport source (output valid, output line_code, input ready);
  modport sink   (input valid, input line_code, output ready);
endinterface

// ===== sv/lme_in_stage.sv =====
// ----------------------------------------------------------------------------
// lme_in_stage
// Input register. Holds one accepted bit and issues its preamble first when
// the bit starts a frame.
// ----------------------------------------------------------------------------
module lme_in_stage import lme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lme_bit_if.sink     bits,
  input  logic        load,
  output issue_t      issue
);

  logic hold_valid;
  logic hold_bit;
  logic hold_start;
  logic pre_sent;
  logic pending;

  // The preamble is still owed for a held frame-start bit.
  assign pending = hold_start && !pre_sent;

  assign issue.valid         = hold_valid;
  assign issue.send_preamble = pending;
  assign issue.data_bit      = hold_bit;

  // Free when empty, or when the held bit issues its final result now.
  assign bits.ready = !hold_valid || (load && !pending);

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      pre_sent   <= 1'b0;
    end else if (bits.valid && bits.ready) begin
      hold_valid <= 1'b1;
      pre_sent   <= 1'b0;
    end else if (hold_valid && load) begin
      if (pending) begin
        pre_sent <= 1'b1;
      end else begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (bits.valid && bits.ready) begin
      hold_bit   <= bits.data_bit;
      hold_start <= bits.frame_start;
    end
  end

endmodule

// ===== sv/lme_coder.sv =====
// ----------------------------------------------------------------------------
// lme_coder
// Line code register, previous pair and the encoding logic for one pair.
// ----------------------------------------------------------------------------
module lme_coder import lme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lme_cfg_if.sink     cfg,
  input  issue_t      issue,
  input  logic        load,
  output result_t     result
);

  line_code_t line_code;
  logic       prev_first;
  logic       prev_second;
  logic       data_first;
  logic       data_second;

  // The register is always writable.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_code <= LINE_CODE_RESET;
    end else if (cfg.valid) begin
      line_code <= line_code_t'(cfg.line_code);
    end
  end

  // Data pair for the selected line code.
  always_comb begin
    unique case (line_code)
      CODE_NRZI: begin
        data_first  = issue.data_bit ? !prev_first : prev_first;
        data_second = issue.data_bit ? !prev_first : prev_second;
      end
      CODE_NRZ: begin
        data_first  = issue.data_bit;
        data_second = issue.data_bit;
      end
      CODE_MANCHESTER: begin
        data_first  = issue.data_bit;
        data_second = !issue.data_bit;
      end
      CODE_DIFF_MANCH: begin
        data_first  = issue.data_bit ? prev_second : prev_first;
        data_second = issue.data_bit ? prev_first  : prev_second;
      end
      default: begin
        data_first  = prev_first;
        data_second = prev_second;
      end
    endcase
  end

  // The preamble goes out ahead of the data pair of a frame start.
  always_comb begin
    if (issue.send_preamble) begin
      result.first_half  = PREAMBLE_FIRST;
      result.second_half = PREAMBLE_SECOND;
      result.is_preamble = 1'b1;
      result.last        = 1'b0;
    end else begin
      result.first_half  = data_first;
      result.second_half = data_second;
      result.is_preamble = 1'b0;
      result.last        = 1'b1;
    end
  end

  // Every issued pair becomes the previous pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_first  <= PREAMBLE_FIRST;
      prev_second <= PREAMBLE_SECOND;
    end else if (issue.valid && load) begin
      prev_first  <= result.first_half;
      prev_second <= result.second_half;
    end
  end

endmodule

// ===== sv/lme_out_reg.sv =====
// ----------------------------------------------------------------------------
// lme_out_reg
// Result register. Takes a new pair whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module lme_out_reg import lme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        issue_valid,
  input  result_t     result,
  output logic        load,
  lme_level_if.source levels
);

  logic    out_valid;
  result_t out_data;

  assign load = !out_valid || levels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && issue_valid) begin
      out_data <= result;
    end
  end

  assign levels.valid       = out_valid;
  assign levels.first_half  = out_data.first_half;
  assign levels.second_half = out_data.second_half;
  assign levels.is_preamble = out_data.is_preamble;
  assign levels.last        = out_data.last;

endmodule

// ===== sv/multi_mode_line_encoder.sv =====
// ----------------------------------------------------------------------------
// multi_mode_line_encoder
// Encodes one data bit per transaction into two half-bit line levels.
// ----------------------------------------------------------------------------
// Channels: bits carries data_bit and frame_start; levels returns first_half,
// second_half, is_preamble and last; cfg writes the two-bit line code
// (NRZI, NRZ, Manchester, differential Manchester) and is always ready.
// A bit that starts a frame yields two transactions on levels: the 0,1
// preamble, then the data pair with last set. Other bits yield one.
// Path: a bit is held in the input register, encoded combinationally and
// captured in the result register.
// Throughput: one bit per cycle while levels is ready; a frame-start bit
// occupies the input register until both of its pairs have been issued.
// A new bit is accepted while a finished pair waits in the result register.
// When levels stalls, the result register holds its pair and the input
// register fills, after which bits.ready drops.
// Reset: both registers empty, line code Manchester, previous pair 0,1.
// ----------------------------------------------------------------------------
module multi_mode_line_encoder import lme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lme_cfg_if.sink     cfg,
  lme_bit_if.sink     bits,
  lme_level_if.source levels
);

  issue_t  issue;
  result_t result;
  logic    load;

  // Input register and preamble sequencing.
  lme_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .bits  (bits),
    .load  (load),
    .issue (issue)
  );

  // Encoding logic and line state.
  lme_coder u_coder (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .issue  (issue),
    .load   (load),
    .result (result)
  );

  // Result register.
  lme_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue.valid),
    .result      (result),
    .load        (load),
    .levels      (levels)
  );

endmodule

// ===== sv/lme_checker.sv =====
// ----------------------------------------------------------------------------
// lme_checker
// Port-level checks of the line encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_mode_line_encoder_assert.svh"

module lme_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_first,
  input logic out_second,
  input logic out_preamble,
  input logic out_last
);

  // A stalled transaction keeps its levels and flags.
  `LME_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable({out_first, out_second, out_preamble, out_last}), "stalled result changed")

  // A preamble is the pair 0,1 and never closes an item.
  `LME_ASSERT_NOW(a_preamble_form, out_valid && out_preamble, !out_first && out_second && !out_last, "malformed preamble")

  // The data pair of a frame start follows its preamble directly.
  `LME_ASSERT_NEXT(a_data_after_pre, out_valid && out_ready && out_preamble, out_valid && !out_preamble && out_last, "no data pair after preamble")

  // Reset empties the result register.
  `LME_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind multi_mode_line_encoder lme_checker u_lme_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (levels.valid),
  .out_ready    (levels.ready),
  .out_first    (levels.first_half),
  .out_second   (levels.second_half),
  .out_preamble (levels.is_preamble),
  .out_last     (levels.last)
);

// ===== tb/multi_mode_line_encoder_test.sv =====
// ----------------------------------------------------------------------------
// multi_mode_line_encoder_test
// Self-checking testbench for the multi-mode line encoder. Bits go in on the
// bits channel under every line code. A scoreboard predicts the preamble and
// data pairs that each bit yields and checks every pair taken from the levels
// channel, in order. Both sides idle at random, and once the receiver holds
// off long enough to back up the input.
// ----------------------------------------------------------------------------
module multi_mode_line_encoder_test;
  import lme_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int IDLE_PERCENT = 13;

  // Predicts the line pairs of each accepted bit and checks received pairs.
  class line_encoder_scoreboard;
    line_code_t code;
    logic       prev_first;
    logic       prev_second;
    result_t    pairs_due[$];
    int         errors;

    function new();
      code = LINE_CODE_RESET;
      prev_first = PREAMBLE_FIRST;
      prev_second = PREAMBLE_SECOND;
      errors = 0;
    endfunction

    // Queue the pairs that one accepted bit transaction must produce.
    function void note_bit(logic data_bit, logic frame_start);
      result_t pair;
      logic    lvl_a;
      logic    lvl_b;
      if (frame_start) begin
        prev_first = PREAMBLE_FIRST;
        prev_second = PREAMBLE_SECOND;
        pair = '{PREAMBLE_FIRST, PREAMBLE_SECOND, 1'b1, 1'b0};
        pairs_due.push_back(pair);
      end
      case (code)
        CODE_NRZI: begin
          // A one toggles the level across both halves; a zero holds the pair.
          if (data_bit) begin
            lvl_a = !prev_first;
            lvl_b = lvl_a;
          end else begin
            lvl_a = prev_first;
            lvl_b = prev_second;
          end
        end
        CODE_NRZ: begin
          lvl_a = data_bit;
          lvl_b = data_bit;
        end
        CODE_MANCHESTER: begin
          lvl_a = data_bit;
          lvl_b = !data_bit;
        end
        default: begin
          // A one swaps the previous pair; a zero repeats it.
          if (data_bit) begin
            lvl_a = prev_second;
            lvl_b = prev_first;
          end else begin
            lvl_a = prev_first;
            lvl_b = prev_second;
          end
        end
      endcase
      pair = '{lvl_a, lvl_b, 1'b0, 1'b1};
      pairs_due.push_back(pair);
      prev_first = lvl_a;
      prev_second = lvl_b;
    endfunction

    // Compare one received pair with the oldest predicted one.
    function void check_pair(result_t got);
      result_t want;
      if (pairs_due.size() == 0) begin
        $error("unexpected level transaction %b%b", got.first_half, got.second_half);
        errors++;
        return;
      end
      want = pairs_due.pop_front();
      if (got.first_half !== want.first_half) begin
        $error("first_half: expected %b, actual %b", want.first_half, got.first_half);
        errors++;
      end
      if (got.second_half !== want.second_half) begin
        $error("second_half: expected %b, actual %b", want.second_half, got.second_half);
        errors++;
      end
      if (got.is_preamble !== want.is_preamble) begin
        $error("is_preamble: expected %b, actual %b", want.is_preamble, got.is_preamble);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, actual %b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int   hold_asked;
  int   hold_served;
  int   quiet_cycles = 0;

  line_encoder_scoreboard sb;

  lme_cfg_if   cfg_ch ();
  lme_bit_if   bit_ch ();
  lme_level_if lvl_ch ();

  multi_mode_line_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .bits   (bit_ch),
    .levels (lvl_ch)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note accepted bits and check accepted pairs.
  always @(posedge clk) begin
    if (!rst && bit_ch.valid && bit_ch.ready) begin
      sb.note_bit(bit_ch.data_bit, bit_ch.frame_start);
    end
    if (!rst && lvl_ch.valid && lvl_ch.ready) begin
      sb.check_pair('{lvl_ch.first_half, lvl_ch.second_half, lvl_ch.is_preamble,
                      lvl_ch.last});
    end
  end

  // End the run when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if ((bit_ch.valid && bit_ch.ready) || (lvl_ch.valid && lvl_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multi_mode_line_encoder_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is asked.
  initial begin
    lvl_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        lvl_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        lvl_ch.ready <= !(idle_on && ($urandom_range(0, 99) < IDLE_PERCENT));
      end
    end
  end

  // Offer one bit, with a random gap first, and wait until it is taken.
  task automatic send_bit(logic data_bit, logic frame_start);
    while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
      bit_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bit_ch.valid <= 1'b1;
    bit_ch.data_bit <= data_bit;
    bit_ch.frame_start <= frame_start;
    do @(posedge clk); while (!bit_ch.ready);
  endtask

  // Stop offering bits and wait until every predicted pair has arrived.
  // The first edge lets the last accepted bit reach the scoreboard.
  task automatic settle_out();
    bit_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pairs_due.size() != 0) @(posedge clk);
  endtask

  // Write the line code once the encoder has drained.
  task automatic write_code(line_code_t code);
    settle_out();
    cfg_ch.valid <= 1'b1;
    cfg_ch.line_code <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.code = code;
    cfg_ch.valid <= 1'b0;
  endtask

  // Main sequence: directed bits under each code, then random phases.
  initial begin
    line_code_t code;
    int         count;
    sb = new();
    rst = 1'b1;
    idle_on = 1'b1;
    hold_asked = 0;
    hold_served = 0;
    bit_ch.valid = 1'b0;
    bit_ch.data_bit = 1'b0;
    bit_ch.frame_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.line_code = LINE_CODE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bits right after reset continue from the reset pair, with no frame start.
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);

    // Each code from its preamble: starts, ones, zeros and a later frame start.
    for (int c = 0; c < 4; c++) begin
      write_code(line_code_t'(c));
      send_bit(1'b1, 1'b1);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
    end

    // Random phases; a code change mid-frame carries on from the last pair.
    for (int phase = 0; phase < 12; phase++) begin
      code = (phase == 0) ? CODE_NRZI :
             (phase == 1) ? CODE_DIFF_MANCH : line_code_t'($urandom_range(0, 3));
      write_code(code);
      idle_on = (phase != 5);
      count = (phase == 5) ? 150 : $urandom_range(40, 70);
      for (int i = 0; i < count; i++) begin
        if (phase == 8 && i == 10) begin
          hold_asked++;
        end
        if (phase == 3 && i == count / 2) begin
          settle_out();
        end
        send_bit(1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0));
      end
    end

    settle_out();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pairs_due.size() == 0) begin
      $display("multi_mode_line_encoder_test: clean");
    end else begin
      if (sb.pairs_due.size() != 0) begin
        $error("%0d predicted level transactions never arrived", sb.pairs_due.size());
      end
      $display("multi_mode_line_encoder_test: errors");
    end
    $finish;
  end

endmodule
